### rtl/pdrc_pkg.sv
`timescale 1ns / 1ps

package pdrc_pkg;

    // Parameter defaults
    localparam int FREQ_WIDTH_DEF = 32;

    // Configuration port
    localparam int IDX_W = 3;
    localparam int CFG_W = 28;

    localparam logic [IDX_W-1:0] IDX_LO_OFFSET     = 3'd0;
    localparam logic [IDX_W-1:0] IDX_REFCLK_HZ     = 3'd1;
    localparam logic [IDX_W-1:0] IDX_R_DIV         = 3'd2;
    localparam logic [IDX_W-1:0] IDX_PRESCALER_SEL = 3'd3;
    localparam logic [IDX_W-1:0] IDX_FREQ_MULT     = 3'd4;
    localparam logic [IDX_W-1:0] IDX_N_MODE_BITS   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_POWER_DOWN    = 3'd6;

    // Register field widths
    localparam int OFFSET_W = 24;
    localparam int REFCLK_W = 28;
    localparam int RDIV_W   = 14;
    localparam int DEN_W    = 16;

    // Register reset values
    localparam logic [REFCLK_W-1:0] REFCLK_RST = 28'd64000000;
    localparam logic [RDIV_W-1:0]   RDIV_RST   = 14'd16;
    localparam logic [1:0]          PSEL_RST   = 2'd1;
    localparam logic [1:0]          MULT_RST   = 2'd1;

    // Prescaler codes
    localparam logic [1:0] PSEL_8  = 2'd0;
    localparam logic [1:0] PSEL_16 = 2'd1;

    // Counter widths: feedback count, B counter, A counter
    localparam int N_W   = 19;
    localparam int B_W   = 13;
    localparam int A_W   = 5;
    localparam int BF_W  = N_W - 3;
    localparam logic [BF_W-1:0] B_MAX = 16'd8191;

    // Latch words
    localparam int WORD_W = 24;
    localparam logic [WORD_W-1:0] R_CONST = 24'h340000;
    localparam logic [WORD_W-1:0] C_CONST = 24'h0FC924;
    localparam logic [WORD_W-1:0] R_ADDR  = 24'd1;
    localparam logic [WORD_W-1:0] N_ADDR  = 24'd2;

    // Request tag that travels down the divider rows
    typedef struct packed {
        logic           valid;
        logic           ok;
        logic           ovf;
        logic [B_W-1:0] b;
        logic [A_W-1:0] a;
    } tag_t;

endpackage

### rtl/pdrc_div_cell.sv
`timescale 1ns / 1ps

module pdrc_div_cell #(
    parameter int NUM_W = 51,
    parameter int DIV_W = 29,
    parameter int QUO_W = 19,
    parameter int EXT_W = 51,
    parameter int BIT   = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdrc_pkg::tag_t       tag_in,
    input  logic [NUM_W-1:0]     rem_in,
    input  logic [QUO_W-1:0]     quo_in,
    input  logic [DIV_W-1:0]     div,
    output pdrc_pkg::tag_t       tag_out,
    output logic [NUM_W-1:0]     rem_out,
    output logic [QUO_W-1:0]     quo_out
);

    pdrc_pkg::tag_t   tag_reg;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [EXT_W-1:0] sh, rem_ext, diff;
    logic             ge;

    // Trial subtract of the divisor at this quotient bit
    always_comb
    begin
        sh       = EXT_W'(div) << BIT;
        rem_ext  = EXT_W'(rem_in);
        diff     = rem_ext - sh;
        ge       = rem_ext >= sh;
        rem_next = ge ? diff[NUM_W-1:0] : rem_in;
        quo_next = quo_in;
        quo_next[BIT] = ge;
    end

    // Hand the request to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign tag_out = tag_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

### rtl/pdrc_div_chain.sv
`timescale 1ns / 1ps

module pdrc_div_chain #(
    parameter int NUM_W = 51,
    parameter int DIV_W = 29,
    parameter int QUO_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pdrc_pkg::tag_t   tag_in,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DIV_W-1:0] div,
    output pdrc_pkg::tag_t   tag_out,
    output logic [QUO_W-1:0] quo_out
);

    localparam int EXT_W = (NUM_W > DIV_W + QUO_W) ? NUM_W : DIV_W + QUO_W;

    pdrc_pkg::tag_t   tag_entry;
    pdrc_pkg::tag_t   tag_c [QUO_W];
    logic [NUM_W-1:0] rem_c [QUO_W];
    logic [QUO_W-1:0] quo_c [QUO_W];

    // Flag a quotient that does not fit in QUO_W bits
    always_comb
    begin
        tag_entry     = tag_in;
        tag_entry.ovf = EXT_W'(num_in) >= (EXT_W'(div) << QUO_W);
    end

    // One cell per quotient bit, most significant first
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            pdrc_div_cell #(
                .NUM_W(NUM_W), .DIV_W(DIV_W), .QUO_W(QUO_W),
                .EXT_W(EXT_W), .BIT(QUO_W - 1)
            ) u_cell (
                .clk(clk), .rst_n(rst_n),
                .tag_in(tag_entry), .rem_in(num_in), .quo_in('0), .div(div),
                .tag_out(tag_c[i]), .rem_out(rem_c[i]), .quo_out(quo_c[i])
            );
        end
        else
        begin : g_next
            pdrc_div_cell #(
                .NUM_W(NUM_W), .DIV_W(DIV_W), .QUO_W(QUO_W),
                .EXT_W(EXT_W), .BIT(QUO_W - 1 - i)
            ) u_cell (
                .clk(clk), .rst_n(rst_n),
                .tag_in(tag_c[i-1]), .rem_in(rem_c[i-1]), .quo_in(quo_c[i-1]),
                .div(div),
                .tag_out(tag_c[i]), .rem_out(rem_c[i]), .quo_out(quo_c[i])
            );
        end
    end

    assign tag_out = tag_c[QUO_W-1];
    assign quo_out = quo_c[QUO_W-1];

endmodule

### rtl/pll_divider_register_calculator.sv
`timescale 1ns / 1ps
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+------------------------
// request   | target_freq_hz                               | start & !busy
// result    | ok, r_word, control_word, n_word,            | done, one cycle
//           | actual_freq_hz                               |
// config    | cfg_index, cfg_data                          | cfg_valid & cfg_ready
//
// One request is taken every cycle; busy stays low.
// The pipeline has two input stages, a row of 19 restoring divide cells for the feedback
// count, one split stage, a row of FREQ_WIDTH cells for the achieved frequency and the
// output register.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults.
// The receiver cannot stall; each result shows for exactly one cycle with done.

module pll_divider_register_calculator #(
    parameter int FREQ_WIDTH = pdrc_pkg::FREQ_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 target_freq_hz,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pdrc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [pdrc_pkg::CFG_W-1:0]  cfg_data,
    output logic                        done,
    output logic                        ok,
    output logic [23:0]                 r_word,
    output logic [23:0]                 control_word,
    output logic [23:0]                 n_word,
    output logic [31:0]                 actual_freq_hz
);

    localparam int TIN_W  = (FREQ_WIDTH < 32) ? FREQ_WIDTH : 32;
    localparam int NUM1_W = TIN_W + 19;
    localparam int DIV1_W = pdrc_pkg::REFCLK_W + 1;
    localparam int NUM2_W = pdrc_pkg::N_W + pdrc_pkg::REFCLK_W + 2;
    localparam int DIV2_W = pdrc_pkg::DEN_W + 1;
    localparam logic [31:0] SAT32 = 32'((64'd1 << FREQ_WIDTH) - 64'd1);

    // Configuration registers
    logic [pdrc_pkg::OFFSET_W-1:0] lo_offset_reg;
    logic [pdrc_pkg::REFCLK_W-1:0] refclk_reg;
    logic [pdrc_pkg::RDIV_W-1:0]   r_div_reg;
    logic [1:0]                    psel_reg;
    logic [1:0]                    mult_reg;
    logic [2:0]                    nmode_reg;
    logic [1:0]                    pd_reg;

    // Pipeline
    logic                          s1_valid_reg;
    logic [TIN_W:0]                f_reg, f_next;
    logic [TIN_W+1:0]              sum;
    logic [1:0]                    mult_eff;
    logic [pdrc_pkg::DEN_W-1:0]    den;
    logic [NUM1_W-1:0]             num1_reg, num1_next;
    pdrc_pkg::tag_t                tag1_reg, tag1_next;
    pdrc_pkg::tag_t                tag2, tag3_reg, tag3_next, tag4;
    logic [pdrc_pkg::N_W-1:0]      n;
    logic [pdrc_pkg::BF_W-1:0]     b_full;
    logic [pdrc_pkg::A_W-1:0]      a_val;
    logic [NUM2_W-1:0]             num2_reg, num2_next;
    logic [FREQ_WIDTH-1:0]         act;

    // Result registers
    logic        done_reg;
    logic        ok_reg;
    logic [23:0] r_word_reg, control_word_reg, n_word_reg;
    logic [31:0] actual_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Take configuration writes; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_offset_reg <= '0;
            refclk_reg    <= pdrc_pkg::REFCLK_RST;
            r_div_reg     <= pdrc_pkg::RDIV_RST;
            psel_reg      <= pdrc_pkg::PSEL_RST;
            mult_reg      <= pdrc_pkg::MULT_RST;
            nmode_reg     <= '0;
            pd_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pdrc_pkg::IDX_LO_OFFSET:     lo_offset_reg <= cfg_data[23:0];
                pdrc_pkg::IDX_REFCLK_HZ:     refclk_reg    <= cfg_data[27:0];
                pdrc_pkg::IDX_R_DIV:         r_div_reg     <= cfg_data[13:0];
                pdrc_pkg::IDX_PRESCALER_SEL: psel_reg      <= cfg_data[1:0];
                pdrc_pkg::IDX_FREQ_MULT:     mult_reg      <= cfg_data[1:0];
                pdrc_pkg::IDX_N_MODE_BITS:   nmode_reg     <= cfg_data[2:0];
                pdrc_pkg::IDX_POWER_DOWN:    pd_reg        <= cfg_data[1:0];
                default:                     ;
            endcase
        end
    end

    // Add the offset and clamp a negative sum to zero
    always_comb
    begin
        sum = {2'b00, target_freq_hz[TIN_W-1:0]}
            + {{(TIN_W + 2 - pdrc_pkg::OFFSET_W){lo_offset_reg[pdrc_pkg::OFFSET_W-1]}},
               lo_offset_reg};
        f_next = sum[TIN_W+1] ? '0 : sum[TIN_W:0];
    end

    // Scale the frequency and add half the divisor for rounding
    always_comb
    begin
        mult_eff  = (mult_reg == 2'd0) ? 2'd1 : mult_reg;
        den       = pdrc_pkg::DEN_W'(r_div_reg) * pdrc_pkg::DEN_W'(mult_eff);
        num1_next = ((NUM1_W'(f_reg) * NUM1_W'(den)) << 1) + NUM1_W'(refclk_reg);
        tag1_next       = '0;
        tag1_next.valid = s1_valid_reg;
        tag1_next.ok    = (refclk_reg != '0) && (r_div_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            tag1_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= start;
            tag1_reg     <= tag1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg    <= f_next;
        num1_reg <= num1_next;
    end

    // Feedback count n = round(f * mult * r_div / refclk)
    pdrc_div_chain #(
        .NUM_W(NUM1_W), .DIV_W(DIV1_W), .QUO_W(pdrc_pkg::N_W)
    ) u_n_chain (
        .clk(clk), .rst_n(rst_n),
        .tag_in(tag1_reg), .num_in(num1_reg), .div({refclk_reg, 1'b0}),
        .tag_out(tag2), .quo_out(n)
    );

    // Split n into B and A, check the counters, set up the frequency divide
    always_comb
    begin
        case (psel_reg)
            pdrc_pkg::PSEL_8:
            begin
                b_full = pdrc_pkg::BF_W'(n >> 3);
                a_val  = {2'b00, n[2:0]};
            end
            pdrc_pkg::PSEL_16:
            begin
                b_full = pdrc_pkg::BF_W'(n >> 4);
                a_val  = {1'b0, n[3:0]};
            end
            default:
            begin
                b_full = pdrc_pkg::BF_W'(n >> 5);
                a_val  = n[4:0];
            end
        endcase
        tag3_next       = '0;
        tag3_next.valid = tag2.valid;
        tag3_next.ok    = tag2.ok && !tag2.ovf
                          && (b_full >= pdrc_pkg::BF_W'(a_val))
                          && (b_full <= pdrc_pkg::B_MAX);
        tag3_next.b     = b_full[pdrc_pkg::B_W-1:0];
        tag3_next.a     = a_val;
        num2_next = ((NUM2_W'(n) * NUM2_W'(refclk_reg)) << 1) + NUM2_W'(den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag3_reg <= '0;
        end
        else
        begin
            tag3_reg <= tag3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num2_reg <= num2_next;
    end

    // Achieved frequency = round(n * refclk / (r_div * mult))
    pdrc_div_chain #(
        .NUM_W(NUM2_W), .DIV_W(DIV2_W), .QUO_W(FREQ_WIDTH)
    ) u_f_chain (
        .clk(clk), .rst_n(rst_n),
        .tag_in(tag3_reg), .num_in(num2_reg), .div({den, 1'b0}),
        .tag_out(tag4), .quo_out(act)
    );

    // Pack the latch words; zero everything on a failed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag4.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= tag4.ok;
        if (tag4.ok)
        begin
            r_word_reg       <= pdrc_pkg::R_CONST | (24'(r_div_reg) << 2)
                                | pdrc_pkg::R_ADDR;
            control_word_reg <= (24'(psel_reg) << 22) | (24'(pd_reg) << 20)
                                | pdrc_pkg::C_CONST;
            n_word_reg       <= (24'(nmode_reg) << 21) | (24'(tag4.b) << 8)
                                | (24'(tag4.a) << 2) | pdrc_pkg::N_ADDR;
            actual_reg       <= tag4.ovf ? SAT32 : 32'(act);
        end
        else
        begin
            r_word_reg       <= '0;
            control_word_reg <= '0;
            n_word_reg       <= '0;
            actual_reg       <= '0;
        end
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign r_word         = r_word_reg;
    assign control_word   = control_word_reg;
    assign n_word         = n_word_reg;
    assign actual_freq_hz = actual_reg;

endmodule

### rtl/pdrc_checker.sv
`timescale 1ns / 1ps

module pdrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic        ok,
    input logic [23:0] r_word,
    input logic [23:0] control_word,
    input logic [23:0] n_word,
    input logic [31:0] actual_freq_hz
);

    // Failed request shows all words zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (r_word == 24'd0 && control_word == 24'd0
                           && n_word == 24'd0 && actual_freq_hz == 32'd0))
        else $error("failed request carries nonzero words");

    // Good request carries the latch addresses
    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> (r_word[1:0] == 2'd1 && control_word[1:0] == 2'd0
                          && n_word[1:0] == 2'd2))
        else $error("latch address bits wrong");

    // A counter never exceeds B counter
    a_ab: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> ({8'd0, n_word[6:2]} <= n_word[20:8]))
        else $error("A counter above B counter");

    // Fixed fields of the R and control words
    a_const: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> (r_word[23:16] == 8'h34 && control_word[19:0] == 20'hFC924))
        else $error("constant latch fields wrong");

endmodule

bind pll_divider_register_calculator pdrc_checker u_pdrc_checker (
    .clk(clk), .rst_n(rst_n), .done(done), .ok(ok), .r_word(r_word),
    .control_word(control_word), .n_word(n_word), .actual_freq_hz(actual_freq_hz)
);
